/* hw/rtl/nearest_target_aim_and_fire_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the nearest target aim and fire block
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_TARGET_AIM_AND_FIRE_MACROS_SVH
`define NEAREST_TARGET_AIM_AND_FIRE_MACROS_SVH

// Property that must hold at every edge outside reset
`define NTAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define NTAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ntaf_pkg.sv */
// ----------------------------------------------------------------------------
// ntaf_pkg
// Types, constants and helper functions for the nearest target aim and fire block.
// ----------------------------------------------------------------------------
package ntaf_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int FRAC_SHIFT    = 28 - COORD_WIDTH;
  localparam int AXIS_W        = COORD_WIDTH + 2;
  localparam int DSQ_W         = 2 * COORD_WIDTH;
  localparam int SS_W          = 2 * (AXIS_W - 2) + 2;
  localparam int SQ_IN_W       = SS_W + 2 * FRAC_SHIFT;
  localparam int ROOT_W        = SQ_IN_W / 2;
  localparam int CORDIC_FRAC   = 20;
  localparam int CORDIC_SCALE  = FRAC_SHIFT + CORDIC_FRAC;
  localparam int CORDIC_W      = 53;
  localparam int ANG_W         = 20;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(102944);
  localparam logic signed [15:0]      YAW_MAX     = 16'sd25736;
  localparam logic signed [15:0]      PITCH_MAX   = 16'sd12868;

  localparam logic OP_POINT  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X      = 3'd0,
    CFG_OFFSET_Y      = 3'd1,
    CFG_OFFSET_Z      = 3'd2,
    CFG_DRIFT_THRESH  = 3'd3,
    CFG_POS_TOL       = 3'd4,
    CFG_STABLE_LIMIT  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
    logic [15:0]        drift_threshold;
    logic [15:0]        position_tolerance;
    logic [7:0]         stable_limit;
  } cfg_t;

  typedef enum logic {
    JOB_POINT  = 1'b0,
    JOB_REPORT = 1'b1
  } job_kind_e;

  // Point job: a, b, c are turret axes x, y, z. Report job: a yaw, b pitch.
  typedef struct packed {
    job_kind_e                kind;
    logic signed [AXIS_W-1:0] a;
    logic signed [AXIS_W-1:0] b;
    logic signed [AXIS_W-1:0] c;
  } job_t;

  // Arctangent of 2^-i in units of 2^-16 rad
  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = ANG_W'(51472);
      5'd1:    v = ANG_W'(30386);
      5'd2:    v = ANG_W'(16055);
      5'd3:    v = ANG_W'(8150);
      5'd4:    v = ANG_W'(4091);
      5'd5:    v = ANG_W'(2047);
      5'd6:    v = ANG_W'(1024);
      5'd7:    v = ANG_W'(512);
      5'd8:    v = ANG_W'(256);
      5'd9:    v = ANG_W'(128);
      5'd10:   v = ANG_W'(64);
      5'd11:   v = ANG_W'(32);
      5'd12:   v = ANG_W'(16);
      5'd13:   v = ANG_W'(8);
      5'd14:   v = ANG_W'(4);
      5'd15:   v = ANG_W'(2);
      5'd16:   v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round 2^-16 rad to 2^-13 rad, half up, then clamp to +-lim
  function automatic logic signed [15:0] to_out_angle(input logic signed [ANG_W-1:0] a,
                                                      input logic signed [15:0] lim);
    logic signed [ANG_W:0] r;
    logic signed [ANG_W:0] q;
    logic signed [ANG_W:0] hi;
    logic signed [15:0]    res;
    r  = {a[ANG_W-1], a} + (ANG_W+1)'(4);
    q  = r >>> 3;
    hi = {{(ANG_W+1-16){lim[15]}}, lim};
    if (q > hi) begin
      res = lim;
    end else if (q < -hi) begin
      res = -lim;
    end else begin
      res = q[15:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/ntaf_queue.sv */
// ----------------------------------------------------------------------------
// ntaf_queue
// Short job queue between the classifying front end and the angle back end.
// ----------------------------------------------------------------------------
module ntaf_queue import ntaf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/ntaf_front.sv */
// ----------------------------------------------------------------------------
// ntaf_front
// Accepts beats, keeps the nearest point of a frame, queues frame ends and reports.
// ----------------------------------------------------------------------------
module ntaf_front import ntaf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [IN_DATA_W-1:0] s_tdata_i,
  input  logic                 s_tuser_i,
  input  logic                 s_tlast_i,
  input  cfg_t                 cfg_i,
  output logic                 q_push_o,
  output job_t                 q_data_o,
  input  logic                 q_full_i
);

  typedef enum logic [1:0] {F_IDLE, F_SQ, F_CMP, F_END} fstate_e;

  fstate_e                  st_q;
  logic signed [15:0]       px_q, py_q, pz_q;
  logic                     last_q;
  logic [1:0]               sel_q;
  logic [DSQ_W-1:0]         acc_q;
  logic signed [15:0]       best_x_q, best_y_q, best_z_q;
  logic [DSQ_W-1:0]         best_dsq_q;
  logic                     have_best_q;

  logic                     accept;
  logic signed [15:0]       sq_op;
  logic signed [DSQ_W-1:0]  sq;
  logic signed [AXIS_W-1:0] ax_x, ax_y, ax_z;
  job_t                     rep_job, pt_job;

  assign s_tready_o = (st_q == F_IDLE) && !q_full_i;
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    case (sel_q)
      2'd0:    sq_op = px_q;
      2'd1:    sq_op = py_q;
      default: sq_op = pz_q;
    endcase
    sq = sq_op * sq_op;
  end

  // Camera to turret axes, offsets removed
  assign ax_x = {{2{best_z_q[15]}}, best_z_q} - {{2{cfg_i.offset_x[15]}}, cfg_i.offset_x};
  assign ax_y = -{{2{best_x_q[15]}}, best_x_q} - {{2{cfg_i.offset_y[15]}}, cfg_i.offset_y};
  assign ax_z = -{{2{best_y_q[15]}}, best_y_q} - {{2{cfg_i.offset_z[15]}}, cfg_i.offset_z};

  always_comb begin
    rep_job.kind = JOB_REPORT;
    rep_job.a    = {{2{s_tdata_i[63]}}, s_tdata_i[63:48]};
    rep_job.b    = {{2{s_tdata_i[79]}}, s_tdata_i[79:64]};
    rep_job.c    = '0;
    pt_job.kind  = JOB_POINT;
    pt_job.a     = ax_x;
    pt_job.b     = ax_y;
    pt_job.c     = ax_z;
  end

  assign q_push_o = (accept && s_tuser_i == OP_REPORT) || (st_q == F_END);
  assign q_data_o = (st_q == F_END) ? pt_job : rep_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= F_IDLE;
      px_q        <= '0;
      py_q        <= '0;
      pz_q        <= '0;
      last_q      <= 1'b0;
      sel_q       <= '0;
      acc_q       <= '0;
      best_x_q    <= '0;
      best_y_q    <= '0;
      best_z_q    <= '0;
      best_dsq_q  <= '0;
      have_best_q <= 1'b0;
    end else begin
      case (st_q)
        F_IDLE: begin
          if (accept && s_tuser_i == OP_POINT) begin
            px_q   <= s_tdata_i[15:0];
            py_q   <= s_tdata_i[31:16];
            pz_q   <= s_tdata_i[47:32];
            last_q <= s_tlast_i;
            sel_q  <= '0;
            acc_q  <= '0;
            st_q   <= F_SQ;
          end
        end
        F_SQ: begin
          acc_q <= acc_q + DSQ_W'(sq);
          sel_q <= sel_q + 2'd1;
          if (sel_q == 2'd2) begin
            st_q <= F_CMP;
          end
        end
        F_CMP: begin
          // Strict compare: on a tie the earlier point stays
          if (!have_best_q || acc_q < best_dsq_q) begin
            best_x_q    <= px_q;
            best_y_q    <= py_q;
            best_z_q    <= pz_q;
            best_dsq_q  <= acc_q;
            have_best_q <= 1'b1;
          end
          st_q <= last_q ? F_END : F_IDLE;
        end
        F_END: begin
          have_best_q <= 1'b0;
          st_q        <= F_IDLE;
        end
        default: st_q <= F_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/ntaf_back.sv */
// ----------------------------------------------------------------------------
// ntaf_back
// Computes yaw and pitch by CORDIC, tracks drift and stability, issues results.
// ----------------------------------------------------------------------------
`include "nearest_target_aim_and_fire_macros.svh"

module ntaf_back import ntaf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  output logic                  q_pop_o,
  input  job_t                  q_data_i,
  input  logic                  q_empty_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int SQC_W  = $clog2(ROOT_W);

  typedef enum logic [3:0] {
    B_IDLE, B_SQX, B_SQY, B_YAW_PRE, B_YAW_ROT, B_YAW_END,
    B_SQRT, B_PIT_PRE, B_PIT_ROT, B_PIT_END, B_FIN
  } bstate_e;

  bstate_e                    st_q;
  logic signed [AXIS_W-1:0]   x_q, y_q, z_q;
  logic [SS_W-1:0]            ss_q;
  logic [SQ_IN_W-1:0]         sqin_q;
  logic [ROOT_W:0]            rem_q;
  logic [ROOT_W-1:0]          root_q;
  logic [SQC_W-1:0]           sqc_q;
  logic signed [CORDIC_W-1:0] cx_q, cy_q;
  logic signed [ANG_W-1:0]    ang_q;
  logic [STEP_W-1:0]          step_q;
  logic signed [15:0]         yaw_q, pitch_q, prev_yaw_q, prev_pitch_q;
  logic [16:0]                drift_q;
  logic [7:0]                 cnt_q;
  logic                       out_valid_q;
  logic [OUT_DATA_W-1:0]      out_data_q;

  logic signed [2*AXIS_W-1:0] mul_res;
  logic signed [AXIS_W-1:0]   mul_op;
  logic signed [CORDIC_W-1:0] ax_pre, ay_pre, xs, ys;
  logic [ROOT_W+2:0]          rem2, trial;
  logic signed [16:0]         da, db, dyaw, dpitch;
  logic [16:0]                abs_da, abs_db, abs_dyaw, abs_dpitch;
  logic [18:0]                drift_sum;
  logic [16:0]                drift_d;
  logic [7:0]                 cnt_inc;
  logic                       fire_d;
  logic                       out_free;
  logic signed [15:0]         out_yaw;
  logic                       fin_fire;

  assign q_pop_o    = (st_q == B_IDLE) && !q_empty_i;
  assign out_free   = !out_valid_q || m_tready_i;
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign out_yaw    = out_data_q[15:0];
  assign fin_fire   = (st_q == B_FIN) && out_free && fire_d;

  // One shared multiplier for both squares
  assign mul_op  = (st_q == B_SQX) ? x_q : y_q;
  assign mul_res = mul_op * mul_op;

  always_comb begin
    if (st_q == B_PIT_PRE) begin
      ax_pre = {{(CORDIC_W-ROOT_W){1'b0}}, root_q} <<< CORDIC_FRAC;
      ay_pre = {{(CORDIC_W-AXIS_W){z_q[AXIS_W-1]}}, z_q} <<< CORDIC_SCALE;
    end else begin
      ax_pre = {{(CORDIC_W-AXIS_W){x_q[AXIS_W-1]}}, x_q} <<< CORDIC_SCALE;
      ay_pre = {{(CORDIC_W-AXIS_W){y_q[AXIS_W-1]}}, y_q} <<< CORDIC_SCALE;
    end
    xs = cx_q >>> step_q;
    ys = cy_q >>> step_q;
  end

  // Integer square root, one result bit per cycle
  assign rem2  = {rem_q, sqin_q[SQ_IN_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};

  always_comb begin
    da         = {q_data_i.a[15], q_data_i.a[15:0]} - {prev_yaw_q[15], prev_yaw_q};
    db         = {q_data_i.b[15], q_data_i.b[15:0]} - {prev_pitch_q[15], prev_pitch_q};
    abs_da     = da[16] ? 17'(-da) : 17'(da);
    abs_db     = db[16] ? 17'(-db) : 17'(db);
    dyaw       = {yaw_q[15], yaw_q} - {prev_yaw_q[15], prev_yaw_q};
    dpitch     = {pitch_q[15], pitch_q} - {prev_pitch_q[15], prev_pitch_q};
    abs_dyaw   = dyaw[16] ? 17'(-dyaw) : 17'(dyaw);
    abs_dpitch = dpitch[16] ? 17'(-dpitch) : 17'(dpitch);
    drift_sum  = 19'(drift_q) + 19'(abs_dyaw) + 19'(abs_dpitch);
    drift_d    = drift_sum[17:1];
    cnt_inc    = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
    fire_d     = (drift_d < 17'(cfg_i.drift_threshold)) && (cnt_inc > cfg_i.stable_limit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= B_IDLE;
      x_q          <= '0;
      y_q          <= '0;
      z_q          <= '0;
      ss_q         <= '0;
      sqin_q       <= '0;
      rem_q        <= '0;
      root_q       <= '0;
      sqc_q        <= '0;
      cx_q         <= '0;
      cy_q         <= '0;
      ang_q        <= '0;
      step_q       <= '0;
      yaw_q        <= '0;
      pitch_q      <= '0;
      prev_yaw_q   <= '0;
      prev_pitch_q <= '0;
      drift_q      <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      // Drop the beat once taken, unless a new one is loaded this cycle
      if (out_valid_q && m_tready_i && st_q != B_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        B_IDLE: begin
          if (!q_empty_i) begin
            if (q_data_i.kind == JOB_REPORT) begin
              if (abs_da > 17'(cfg_i.position_tolerance) ||
                  abs_db > 17'(cfg_i.position_tolerance)) begin
                cnt_q <= '0;
              end
            end else begin
              x_q  <= q_data_i.a;
              y_q  <= q_data_i.b;
              z_q  <= q_data_i.c;
              st_q <= B_SQX;
            end
          end
        end
        B_SQX: begin
          ss_q <= mul_res[SS_W-1:0];
          st_q <= B_SQY;
        end
        B_SQY: begin
          sqin_q <= {ss_q + mul_res[SS_W-1:0], {(2*FRAC_SHIFT){1'b0}}};
          rem_q  <= '0;
          root_q <= '0;
          sqc_q  <= '0;
          st_q   <= B_YAW_PRE;
        end
        B_YAW_PRE, B_PIT_PRE: begin
          step_q <= '0;
          if (ax_pre == '0 && ay_pre == '0) begin
            ang_q <= '0;
            st_q  <= (st_q == B_YAW_PRE) ? B_YAW_END : B_PIT_END;
          end else begin
            if (ax_pre < 0) begin
              if (ay_pre >= 0) begin
                cx_q  <= ay_pre;
                cy_q  <= -ax_pre;
                ang_q <= ANG_HALF_PI;
              end else begin
                cx_q  <= -ay_pre;
                cy_q  <= ax_pre;
                ang_q <= -ANG_HALF_PI;
              end
            end else begin
              cx_q  <= ax_pre;
              cy_q  <= ay_pre;
              ang_q <= '0;
            end
            st_q <= (st_q == B_YAW_PRE) ? B_YAW_ROT : B_PIT_ROT;
          end
        end
        B_YAW_ROT, B_PIT_ROT: begin
          if (cy_q > 0) begin
            cx_q  <= cx_q + ys;
            cy_q  <= cy_q - xs;
            ang_q <= ang_q + atan_lut(5'(step_q));
          end else begin
            cx_q  <= cx_q - ys;
            cy_q  <= cy_q + xs;
            ang_q <= ang_q - atan_lut(5'(step_q));
          end
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
            st_q <= (st_q == B_YAW_ROT) ? B_YAW_END : B_PIT_END;
          end
        end
        B_YAW_END: begin
          yaw_q <= to_out_angle(ang_q, YAW_MAX);
          st_q  <= B_SQRT;
        end
        B_SQRT: begin
          if (rem2 >= trial) begin
            rem_q  <= (ROOT_W+1)'(rem2 - trial);
            root_q <= {root_q[ROOT_W-2:0], 1'b1};
          end else begin
            rem_q  <= rem2[ROOT_W:0];
            root_q <= {root_q[ROOT_W-2:0], 1'b0};
          end
          sqin_q <= sqin_q << 2;
          sqc_q  <= sqc_q + SQC_W'(1);
          if (sqc_q == SQC_W'(ROOT_W - 1)) begin
            st_q <= B_PIT_PRE;
          end
        end
        B_PIT_END: begin
          pitch_q <= -to_out_angle(ang_q, PITCH_MAX);
          st_q    <= B_FIN;
        end
        B_FIN: begin
          // Hold until the output register is free
          if (out_free) begin
            drift_q <= drift_d;
            if (drift_d < 17'(cfg_i.drift_threshold)) begin
              cnt_q <= fire_d ? 8'd0 : cnt_inc;
            end else begin
              cnt_q <= '0;
            end
            prev_yaw_q   <= yaw_q;
            prev_pitch_q <= pitch_q;
            out_valid_q  <= 1'b1;
            out_data_q   <= {fire_d, pitch_q[14:0], yaw_q};
            st_q         <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  `NTAF_ASSERT(a_pop_nonempty, !q_pop_o || !q_empty_i, "pop from empty queue")
  `NTAF_ASSERT(a_yaw_range, !out_valid_q || (out_yaw <= YAW_MAX && out_yaw >= -YAW_MAX), "yaw range")
  `NTAF_ASSERT(a_pitch_range, !(st_q == B_FIN) || (pitch_q <= PITCH_MAX && pitch_q >= -PITCH_MAX), "pitch")
  `NTAF_ASSERT_NEXT(a_fire_clears, fin_fire, cnt_q == 8'd0 && out_valid_q, "fire did not clear count")

endmodule

/* hw/rtl/nearest_target_aim_and_fire.sv */
// ----------------------------------------------------------------------------
// nearest_target_aim_and_fire
// Picks the nearest target of each frame and turns it into aim angles and fire.
// ----------------------------------------------------------------------------
//   channel   direction  payload
//   s_*       in         points and position reports, tlast ends a frame
//   m_*       out        aim yaw, aim pitch, fire; one beat per frame
//   cfg_*     in         register index and write data
//
// A point beat passes the front end as three squares on one multiplier and a
// compare, the last point of a frame one more state to queue the frame end; a
// report beat is queued as it is taken. From pop to output register a frame end
// passes two squares, a yaw CORDIC pass, a square root and a pitch CORDIC pass.
// Reset is asynchronous and spares only the queue storage. The job queue lets the
// front take points while the back end finishes a frame or waits on m_tready_i.
module nearest_target_aim_and_fire import ntaf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  // point_x, point_y, point_z, report_yaw, report_pitch
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  // opcode
  input  logic                  s_tuser_i,
  input  logic                  s_tlast_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  // aim_yaw, aim_pitch, fire
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [15:0]           cfg_data_i
);

  cfg_t cfg_q;
  logic q_push, q_pop, q_full, q_empty;
  job_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_x           <= '0;
      cfg_q.offset_y           <= '0;
      cfg_q.offset_z           <= '0;
      cfg_q.drift_threshold    <= 16'd41;
      cfg_q.position_tolerance <= 16'd1229;
      cfg_q.stable_limit       <= 8'd30;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OFFSET_X:     cfg_q.offset_x           <= cfg_data_i;
        CFG_OFFSET_Y:     cfg_q.offset_y           <= cfg_data_i;
        CFG_OFFSET_Z:     cfg_q.offset_z           <= cfg_data_i;
        CFG_DRIFT_THRESH: cfg_q.drift_threshold    <= cfg_data_i;
        CFG_POS_TOL:      cfg_q.position_tolerance <= cfg_data_i;
        CFG_STABLE_LIMIT: cfg_q.stable_limit       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  ntaf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tlast_i  (s_tlast_i),
    .cfg_i      (cfg_q),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .q_full_i   (q_full)
  );

  ntaf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  ntaf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_pop_o    (q_pop),
    .q_data_i   (q_rdata),
    .q_empty_i  (q_empty),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: nearest target aim and fire testbench
// Sends frames of target points and turret position reports, predicts the aim
// angles and the fire flag of each frame, and checks every output beat in
// order. Configuration changes only between phases, with the block idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ntaf_pkg::*;

  class aim_predictor;
    longint off_x, off_y, off_z, drift_thr, pos_tol, fire_limit;
    longint best_x, best_y, best_z, best_dsq, prev_yaw, prev_pitch, drift, settle_cnt;
    bit     have_best;
    logic [31:0] expected_aims[$];
    int     errors, frames, fires, reports;
    longint atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};

    function new();
      off_x = 0; off_y = 0; off_z = 0;
      drift_thr = 41; pos_tol = 1229; fire_limit = 30;
      best_x = 0; best_y = 0; best_z = 0; best_dsq = 0; have_best = 0;
      prev_yaw = 0; prev_pitch = 0; drift = 0; settle_cnt = 0;
      errors = 0; frames = 0; fires = 0; reports = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] v);
      case (idx)
        CFG_OFFSET_X:     off_x = longint'($signed(v));
        CFG_OFFSET_Y:     off_y = longint'($signed(v));
        CFG_OFFSET_Z:     off_z = longint'($signed(v));
        CFG_DRIFT_THRESH: drift_thr = longint'(v);
        CFG_POS_TOL:      pos_tol = longint'(v);
        CFG_STABLE_LIMIT: fire_limit = longint'(v[7:0]);
        default: ;
      endcase
    endfunction

    function longint iabs(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint floor_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    // atan2(ay, ax) in 2^-16 rad
    function longint vector_angle(longint ax, longint ay);
      longint x, y, t, ang, xs, ys;
      ang = 0;
      if (ax == 0 && ay == 0) return 0;
      x = ax <<< 20;
      y = ay <<< 20;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; ang = 102944;
        end else begin
          x = -y; y = t; ang = -102944;
        end
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; ang += atan_tab[i];
        end else begin
          x -= ys; y += xs; ang -= atan_tab[i];
        end
      end
      return ang;
    endfunction

    function longint out_angle(longint a, longint lim);
      longint q;
      q = (a + 4) >>> 3;
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      return q;
    endfunction

    function void note_beat(logic op, logic [79:0] d, logic last);
      longint px, py, pz, dsq, ax, ay, az, yaw, pitch, rs;
      logic fire;
      fire = 0;
      if (op == OP_REPORT) begin
        reports++;
        if (iabs(longint'($signed(d[63:48])) - prev_yaw) > pos_tol ||
            iabs(longint'($signed(d[79:64])) - prev_pitch) > pos_tol)
          settle_cnt = 0;
        return;
      end
      px = longint'($signed(d[15:0]));
      py = longint'($signed(d[31:16]));
      pz = longint'($signed(d[47:32]));
      dsq = px * px + py * py + pz * pz;
      if (!have_best || dsq < best_dsq) begin
        best_x = px; best_y = py; best_z = pz; best_dsq = dsq; have_best = 1;
      end
      if (!last) return;
      ax = best_z - off_x;
      ay = -best_x - off_y;
      az = -best_y - off_z;
      yaw = out_angle(vector_angle(ax <<< 12, ay <<< 12), 25736);
      rs = floor_sqrt(longint'(ax * ax + ay * ay) <<< 24);
      pitch = -out_angle(vector_angle(rs, az <<< 12), 12868);
      drift = ((drift + iabs(yaw - prev_yaw) + iabs(pitch - prev_pitch)) >> 1) & 64'h1FFFF;
      if (drift < drift_thr) begin
        if (settle_cnt < 255) settle_cnt++;
        if (settle_cnt > fire_limit) begin
          fire = 1;
          settle_cnt = 0;
        end
      end else begin
        settle_cnt = 0;
      end
      prev_yaw = yaw;
      prev_pitch = pitch;
      have_best = 0;
      frames++;
      if (fire) fires++;
      expected_aims.push_back({fire, pitch[14:0], yaw[15:0]});
    endfunction

    function void check_aim(logic [31:0] got);
      logic [31:0] want;
      if (expected_aims.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_aims.pop_front();
      if (got[15:0] !== want[15:0]) begin
        $display("%0t: aim_yaw expected %0d actual %0d", $time,
                 $signed(want[15:0]), $signed(got[15:0]));
        errors++;
      end
      if (got[30:16] !== want[30:16]) begin
        $display("%0t: aim_pitch expected %0d actual %0d", $time,
                 $signed(want[30:16]), $signed(got[30:16]));
        errors++;
      end
      if (got[31] !== want[31]) begin
        $display("%0t: fire expected %0b actual %0b", $time, want[31], got[31]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid_i = 1'b0;
  logic                  s_tready_o;
  logic [IN_DATA_W-1:0]  s_tdata_i = '0;
  logic                  s_tuser_i = 1'b0;
  logic                  s_tlast_i = 1'b0;
  logic                  m_tvalid_o;
  logic                  m_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  cfg_idx_e              cfg_index_i = CFG_OFFSET_X;
  logic [15:0]           cfg_data_i = '0;

  aim_predictor pred = new();
  bit calm = 0;
  bit hold_go = 0;
  bit hold_done = 0;
  int rx_hold = 0;
  longint bx, by, bz;

  nearest_target_aim_and_fire dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_top: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) pred.check_aim(m_tdata_o);
      if (hold_go && !hold_done) begin
        hold_done  <= 1'b1;
        rx_hold    <= 400;
        m_tready_i <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= calm || ($urandom_range(99) >= 38);
      end
    end
  end

  task automatic send_beat(logic op, logic last, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z, logic [15:0] ry, logic [15:0] rp);
    while (!calm && $urandom_range(99) < 38) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tlast_i  <= last;
    s_tdata_i  <= {rp, ry, z, y, x};
    do @(posedge clk_i); while (!s_tready_o);
    pred.note_beat(op, {rp, ry, z, y, x}, last);
  endtask

  task automatic point(longint x, longint y, longint z, logic last);
    send_beat(OP_POINT, last, 16'(x), 16'(y), 16'(z), 16'($urandom), 16'($urandom));
  endtask

  task automatic report(longint ry, longint rp);
    send_beat(OP_REPORT, $urandom_range(1), 16'($urandom), 16'($urandom), 16'($urandom),
              16'(ry), 16'(rp));
  endtask

  // Hold the sender until every aim beat is in, then let the back end settle
  task automatic drain();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pred.expected_aims.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pred.set_reg(idx, v);
  endtask

  task automatic set_all(longint ox, longint oy, longint oz, longint thr, longint tol,
                         longint lim);
    write_reg(CFG_OFFSET_X, 16'(ox));
    write_reg(CFG_OFFSET_Y, 16'(oy));
    write_reg(CFG_OFFSET_Z, 16'(oz));
    write_reg(CFG_DRIFT_THRESH, 16'(thr));
    write_reg(CFG_POS_TOL, 16'(tol));
    write_reg(CFG_STABLE_LIMIT, 16'(lim));
  endtask

  function automatic longint srand(int lo, int hi);
    return longint'($urandom_range(hi - lo)) + lo;
  endfunction

  // One random beat or frame: mostly a steady target with jitter and farther decoys
  task automatic random_traffic(output int n);
    int len, near_at;
    n = 0;
    if ($urandom_range(99) < 15) begin
      if ($urandom_range(1))
        report(pred.prev_yaw + srand(-300, 300), pred.prev_pitch + srand(-300, 300));
      else
        report(srand(-25736, 25736), srand(-25736, 25736));
      n = 1;
      return;
    end
    len = $urandom_range(1, 5);
    near_at = $urandom_range(len - 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 20)
        point(srand(-32768, 32767), srand(-32768, 32767), srand(-32768, 32767),
              i == len - 1);
      else if (i == near_at)
        point(bx + srand(-2, 2), by + srand(-2, 2), bz + srand(-2, 2), i == len - 1);
      else
        point(bx + srand(-500, 500), by + srand(-500, 500), bz + srand(3000, 9000),
              i == len - 1);
      n++;
    end
  endtask

  initial begin
    int n, total;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero vector, negative x on the axis, ties, extremes, reports
    point(0, 0, 0, 1);
    point(0, 5, -300, 1);
    point(3, 4, 0, 0);
    point(4, 3, 0, 0);
    point(0, 0, 5, 1);
    point(-32768, -32768, -32768, 0);
    point(32767, 32767, 32767, 1);
    point(-32768, 32767, -32768, 1);
    report(25736, -25736);
    report(-25736, 25736);
    point(100, -200, 32767, 0);
    report(0, 0);
    point(100, -200, 32767, 1);
    drain();
    set_all(0, 0, 0, 65535, 0, 0);
    for (int i = 0; i < 5; i++) point(10, 20, 1000, 1);
    report(pred.prev_yaw, pred.prev_pitch);
    report(pred.prev_yaw + 1, pred.prev_pitch);
    point(10, 20, 1000, 1);
    drain();
    set_all(-32768, 32767, -32768, 0, 65535, 255);
    point(1, 1, 1, 1);
    point(-32768, -32768, 32767, 1);
    drain();

    total = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_all(150, 0, -50, 41, 1229, 30);
        1: set_all(srand(-300, 300), srand(-300, 300), srand(-300, 300), 200, 2000, 0);
        2: set_all(32767, -32768, 32767, 65535, 65535, 254);
        3: set_all(srand(-1000, 1000), srand(-1000, 1000), 0, 60, 0, 2);
        4: set_all(0, 0, 0, 0, 500, 1);
        default: set_all(srand(-32768, 32767), srand(-32768, 32767),
                         srand(-32768, 32767), $urandom_range(65535),
                         $urandom_range(65535), 3);
      endcase
      bx = srand(-3000, 3000);
      by = srand(-3000, 3000);
      bz = srand(500, 20000);
      calm = (ph == 3);
      if (ph == 2) hold_go = 1;
      for (int k = 0; k < 100; k += n) begin
        random_traffic(n);
        if ($urandom_range(99) < 3) bz = srand(500, 20000);
      end
      total += 100;
      drain();
    end
    calm = 0;

    $display("tb_top: %0d frames checked, %0d fire beats, %0d reports", pred.frames,
             pred.fires, pred.reports);
    $display("tb_top: six register settings incl. extremes, receiver hold-off, %0d errors",
             pred.errors);
    if (pred.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
